// ===== rtl/y422q_pkg.sv =====
// ----------------------------------------------------------------------------
// y422q_pkg
// Shared types, constants and helpers for the quarter-scale 4:2:2 to BGRA
// converter.
// ----------------------------------------------------------------------------
package y422q_pkg;

  localparam int MaxLineBytesDefault = 16384;
  localparam int QueueDepth          = 4;

  localparam int                 CfgW          = 15;
  localparam logic [CfgW-1:0]    LineBytesRst  = 15'd3840;

  localparam int PixW = 8;
  localparam int SumW = 20;

  typedef logic signed [SumW-1:0] sum_t;

  // 8.8 fixed-point coefficients
  localparam sum_t CoefY      = 20'sd298;
  localparam sum_t CoefCbBlue = 20'sd541;
  localparam sum_t CoefCbGrn  = 20'sd55;
  localparam sum_t CoefCrGrn  = 20'sd136;
  localparam sum_t CoefCrRed  = 20'sd459;

  localparam logic [PixW-1:0] LumaOffset   = 8'd16;
  localparam logic [PixW-1:0] ChromaOffset = 8'd128;
  localparam logic [PixW-1:0] AlphaOpaque  = 8'hff;

  // One item handed from the front to the back
  typedef struct packed {
    logic [PixW-1:0] cb;
    logic [PixW-1:0] y0;
    logic [PixW-1:0] cr;
    logic            row_end;
  } pix_req_t;

  // Negative clamps to zero, otherwise drop the fraction and saturate.
  function automatic logic [PixW-1:0] sat8(sum_t v);
    logic [PixW-1:0] r;
    if (v[SumW-1]) begin
      r = '0;
    end else if (|v[SumW-2:16]) begin
      r = 8'hff;
    end else begin
      r = v[15:8];
    end
    return r;
  endfunction

endpackage

// ===== rtl/y422q_front.sv =====
// ----------------------------------------------------------------------------
// y422q_front
// Tracks column and line phase, decides which macropixels produce a pixel
// and pushes those into the queue.
// ----------------------------------------------------------------------------
module y422q_front #(
  parameter int MAX_LINE_BYTES = y422q_pkg::MaxLineBytesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [y422q_pkg::CfgW-1:0]  line_bytes_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [y422q_pkg::PixW-1:0]  cb_i,
  input  logic [y422q_pkg::PixW-1:0]  y0_i,
  input  logic [y422q_pkg::PixW-1:0]  cr_i,
  input  logic                        frame_end_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output y422q_pkg::pix_req_t         push_data_o
);

  localparam int PerLineMax = MAX_LINE_BYTES / 4;
  localparam int ColW       = (PerLineMax > 2) ? $clog2(PerLineMax) : 1;
  localparam int PlW        = $clog2(PerLineMax + 1);
  localparam logic [16:0] MaxBytes  = 17'(MAX_LINE_BYTES);
  localparam logic [16:0] MaxMasked = 17'(MAX_LINE_BYTES) & ~17'd7;
  localparam logic [16:0] MinBytes  = 17'd8;

  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      phase_q, phase_d;
  logic [16:0]     pitch_masked, pitch;
  logic [PlW-1:0]  per_line;
  logic [PlW:0]    col_ext;
  logic            emit, accept, line_done;

  always_comb begin
    pitch_masked = {2'b00, line_bytes_i[y422q_pkg::CfgW-1:3], 3'b000};
    priority if (pitch_masked < MinBytes) begin
      pitch = MinBytes;
    end else if (pitch_masked > MaxBytes) begin
      pitch = MaxMasked;
    end else begin
      pitch = pitch_masked;
    end
  end

  assign per_line  = PlW'(pitch >> 2);
  assign col_ext   = (PlW+1)'(col_q);
  assign emit      = (phase_q == 2'd0) && !col_q[0];
  assign line_done = (col_ext + (PlW+1)'(1)) >= (PlW+1)'(per_line);

  // Every transfer needs a free slot so that the position never runs ahead
  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && emit;

  assign push_data_o.cb      = cb_i;
  assign push_data_o.y0      = y0_i;
  assign push_data_o.cr      = cr_i;
  assign push_data_o.row_end = (col_ext + (PlW+1)'(2)) == (PlW+1)'(per_line);

  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    if (accept) begin
      if (frame_end_i) begin
        col_d   = '0;
        phase_d = 2'd0;
      end else if (line_done) begin
        col_d   = '0;
        phase_d = phase_q + 2'd1;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= 2'd0;
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/y422q_queue.sv =====
// ----------------------------------------------------------------------------
// y422q_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module y422q_queue #(
  parameter int DEPTH = y422q_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  y422q_pkg::pix_req_t  push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output y422q_pkg::pix_req_t  pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  y422q_pkg::pix_req_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/y422q_back.sv =====
// ----------------------------------------------------------------------------
// y422q_back
// Colour conversion: products in the first stage, sums and clamping into
// the output register in the second.
// ----------------------------------------------------------------------------
module y422q_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  y422q_pkg::pix_req_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [y422q_pkg::PixW-1:0]  blue_o,
  output logic [y422q_pkg::PixW-1:0]  green_o,
  output logic [y422q_pkg::PixW-1:0]  red_o,
  output logic                        row_end_o
);

  logic                  a_valid_q, b_valid_q, a_ready, b_ready;
  logic signed [9:0]     y0s;
  logic signed [8:0]     cbs, crs;
  y422q_pkg::sum_t       py_q, pbb_q, pgb_q, pgr_q, prr_q;
  y422q_pkg::sum_t       sum_b, sum_g, sum_r;
  logic                  a_row_end_q;
  logic [y422q_pkg::PixW-1:0] blue_q, green_q, red_q;
  logic                  row_end_q;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  assign y0s = $signed({2'b00, in_data_i.y0}) - $signed({2'b00, y422q_pkg::LumaOffset});
  assign cbs = $signed({1'b0, in_data_i.cb}) - $signed({1'b0, y422q_pkg::ChromaOffset});
  assign crs = $signed({1'b0, in_data_i.cr}) - $signed({1'b0, y422q_pkg::ChromaOffset});

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      py_q        <= y422q_pkg::sum_t'(y0s) * y422q_pkg::CoefY;
      pbb_q       <= y422q_pkg::sum_t'(cbs) * y422q_pkg::CoefCbBlue;
      pgb_q       <= y422q_pkg::sum_t'(cbs) * y422q_pkg::CoefCbGrn;
      pgr_q       <= y422q_pkg::sum_t'(crs) * y422q_pkg::CoefCrGrn;
      prr_q       <= y422q_pkg::sum_t'(crs) * y422q_pkg::CoefCrRed;
      a_row_end_q <= in_data_i.row_end;
    end
  end

  assign sum_b = py_q + pbb_q;
  assign sum_g = py_q - pgb_q - pgr_q;
  assign sum_r = py_q + prr_q;

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      blue_q    <= y422q_pkg::sat8(sum_b);
      green_q   <= y422q_pkg::sat8(sum_g);
      red_q     <= y422q_pkg::sat8(sum_r);
      row_end_q <= a_row_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  assign out_valid_o = b_valid_q;
  assign blue_o      = blue_q;
  assign green_o     = green_q;
  assign red_o       = red_q;
  assign row_end_o   = row_end_q;

endmodule

// ===== rtl/ycbcr422_to_bgra_quarter_scale.sv =====
// ----------------------------------------------------------------------------
// ycbcr422_to_bgra_quarter_scale
// Quarter-scale 4:2:2 to BGRA converter with BT.709-style coefficients.
// ----------------------------------------------------------------------------
// Takes one macropixel per clock and sustains that rate while the output is
// not stalled: the position tracker, a four-entry queue and a two-stage
// conversion pipeline (products, then sums and clamping) each move one
// transfer per cycle. Only even macropixels of every fourth line give a BGRA
// pixel, via queue, product stage and output register. The line pitch is read
// through the configuration channel and should only be changed while idle;
// tlast on the input ends the frame and resets column and line phase.
module ycbcr422_to_bgra_quarter_scale #(
  parameter int MAX_LINE_BYTES = y422q_pkg::MaxLineBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i,     // line_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // chroma_blue, luma_first, chroma_red, luma_second
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // blue, green, red, alpha
  output logic        m_axis_tlast    // row_end
);

  logic [y422q_pkg::CfgW-1:0] line_bytes_q;
  logic                       push_valid, push_ready, pop_valid, pop_ready;
  y422q_pkg::pix_req_t        push_data, pop_data;
  logic [y422q_pkg::PixW-1:0] blue, green, red;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q <= y422q_pkg::LineBytesRst;
    end else if (cfg_valid_i) begin
      line_bytes_q <= cfg_data_i;
    end
  end

  y422q_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_bytes_i (line_bytes_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cb_i         (s_axis_tdata[7:0]),
    .y0_i         (s_axis_tdata[15:8]),
    .cr_i         (s_axis_tdata[23:16]),
    .frame_end_i  (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  y422q_queue #(
    .DEPTH (y422q_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  y422q_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_data_i   (pop_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .blue_o      (blue),
    .green_o     (green),
    .red_o       (red),
    .row_end_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {y422q_pkg::AlphaOpaque, red, green, blue};

endmodule

// ===== bench/ycbcr422_to_bgra_quarter_scale_checker.sv =====
// ----------------------------------------------------------------------------
// ycbcr422_to_bgra_quarter_scale_checker
// Watches the configuration, macropixel and pixel channels of the converter.
// It tracks column and line phase, predicts each BGRA pixel and compares it
// field by field with what the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ycbcr422_to_bgra_quarter_scale_checker #(
  parameter int MAX_LINE_BYTES = y422q_pkg::MaxLineBytesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [y422q_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [31:0]              in_data_i,   // chroma_blue, luma_first, chroma_red, luma_second
  input  logic                     in_last_i,   // frame_end
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [31:0]              out_data_i,  // blue, green, red, alpha
  input  logic                     out_last_i,  // row_end
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam int YGain      = 298;
  localparam int CbToBlue   = 541;
  localparam int CbToGreen  = 55;
  localparam int CrToGreen  = 136;
  localparam int CrToRed    = 459;
  localparam int LumaBlack  = 16;
  localparam int ChromaZero = 128;
  localparam logic [7:0] Opaque = 8'hff;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic       row_end;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra_px_t;

  logic [y422q_pkg::CfgW-1:0] line_bytes_q = y422q_pkg::LineBytesRst;
  int unsigned     mp_column    = 0;
  logic [1:0]      line_phase   = '0;
  bgra_px_t        expected_px[$];

  // 8.8 accumulator down to a saturated byte; negatives go to zero
  function automatic logic [7:0] clamp_channel(int acc);
    int whole;
    whole = acc >>> 8;
    if (acc < 0) return 8'd0;
    if (whole > 255) return 8'hff;
    return whole[7:0];
  endfunction

  function automatic int unsigned macropixels_per_line(
    logic [y422q_pkg::CfgW-1:0] pitch_reg);
    int unsigned pitch;
    pitch = int'(pitch_reg) & 32'hffff_fff8;
    if (pitch < 8) pitch = 8;
    if (pitch > MAX_LINE_BYTES) pitch = MAX_LINE_BYTES & 32'hffff_fff8;
    if (pitch < 8) pitch = 8;
    return pitch >> 2;
  endfunction

  task automatic convert_macropixel(logic [31:0] mp, logic frame_end);
    int unsigned per_line;
    int          cb;
    int          luma;
    int          cr;
    bgra_px_t    px;
    per_line = macropixels_per_line(line_bytes_q);
    cb   = int'(mp[7:0]) - ChromaZero;
    luma = (int'(mp[15:8]) - LumaBlack) * YGain;
    cr   = int'(mp[23:16]) - ChromaZero;
    if (line_phase == 2'd0 && mp_column[0] == 1'b0) begin
      px.blue    = clamp_channel(luma + CbToBlue * cb);
      px.green   = clamp_channel(luma - CbToGreen * cb - CrToGreen * cr);
      px.red     = clamp_channel(luma + CrToRed * cr);
      px.alpha   = Opaque;
      px.row_end = (mp_column + 2 == per_line);
      expected_px.push_back(px);
    end
    // a column left beyond a shortened line still ends that line here
    if (mp_column + 1 >= per_line) begin
      mp_column  = 0;
      line_phase = line_phase + 2'd1;
    end else begin
      mp_column = mp_column + 1;
    end
    if (frame_end) begin
      mp_column  = 0;
      line_phase = '0;
    end
  endtask

  task automatic check_pixel(logic [31:0] pix, logic row_end);
    bgra_px_t seen;
    bgra_px_t want;
    seen = {row_end, pix};
    if (expected_px.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MaxReports)
        $display("[%0t] pixel with none expected: b/g/r/a/end %0d/%0d/%0d/%0d/%0b",
                 $realtime, seen.blue, seen.green, seen.red, seen.alpha, seen.row_end);
    end else begin
      want = expected_px.pop_front();
      if (seen !== want) begin
        fail_count_o++;
        if (fail_count_o <= MaxReports)
          $display({"[%0t] pixel mismatch: expected b/g/r/a/end %0d/%0d/%0d/%0d/%0b,",
                    " got %0d/%0d/%0d/%0d/%0b"},
                   $realtime, want.blue, want.green, want.red, want.alpha, want.row_end,
                   seen.blue, seen.green, seen.red, seen.alpha, seen.row_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_bytes_q = y422q_pkg::LineBytesRst;
      mp_column    = 0;
      line_phase   = '0;
      expected_px.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_pixel(out_data_i, out_last_i);
      if (cfg_valid_i && cfg_ready_i) line_bytes_q = cfg_data_i;
      if (in_valid_i && in_ready_i) convert_macropixel(in_data_i, in_last_i);
      pending_o = expected_px.size();
    end
  end

endmodule

// ===== bench/ycbcr422_to_bgra_quarter_scale_tb.sv =====
// ----------------------------------------------------------------------------
// ycbcr422_to_bgra_quarter_scale_tb
// Drives macropixels and line pitch settings into the converter with random
// gaps and output stalls; the checker beside the block scores every pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ycbcr422_to_bgra_quarter_scale_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainPause   = 8;
  localparam int unsigned SettleCycles = 16;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [y422q_pkg::CfgW-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [31:0]      m_axis_tdata;
  logic             m_axis_tlast;

  bit               quiet_tail  = 1'b0;
  int unsigned      cycle_count = 0;
  int unsigned      fail_count;
  int unsigned      pending_px;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  ycbcr422_to_bgra_quarter_scale i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ycbcr422_to_bgra_quarter_scale_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_last_i   (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending_px)
  );

  // pixel sink: random stall bursts between ready runs
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(1, 24)) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic send_macropixel(input logic [7:0] cb, input logic [7:0] y0,
                                 input logic [7:0] cr, input logic [7:0] y1,
                                 input logic frame_end);
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y1, cr, y0, cb};
    s_axis_tlast  <= frame_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // frame_odds of 0 means no frame end at all
  task automatic send_random(input int unsigned count, input int unsigned frame_odds);
    repeat (count) begin
      send_macropixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      frame_odds != 0 && $urandom_range(1, frame_odds) == 1);
    end
  endtask

  task automatic drain_pixels;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_px != 0) @(negedge clk_i);
  endtask

  // only while idle: wait out pixels and the pipeline behind the last one
  task automatic write_line_bytes(input logic [y422q_pkg::CfgW-1:0] pitch);
    drain_pixels();
    repeat (DrainPause) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pitch;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [y422q_pkg::CfgW-1:0] pitch;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pitch, first line: even columns convert, odd ones are dropped
    send_macropixel(8'd128, 8'd16,  8'd128, 8'd0,   1'b0);
    send_macropixel(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
    send_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_macropixel(8'd128, 8'd235, 8'd128, 8'd0,   1'b0);
    send_macropixel(8'd0,   8'd255, 8'd0,   8'd0,   1'b0);
    send_macropixel(8'd255, 8'd0,   8'd255, 8'd0,   1'b0);
    send_macropixel(8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
    send_macropixel(8'd255, 8'd255, 8'd0,   8'd255, 1'b0);
    send_macropixel(8'd128, 8'd235, 8'd128, 8'd0,   1'b0);
    send_macropixel(8'd64,  8'd128, 8'd192, 8'd17,  1'b0);
    send_macropixel(8'd255, 8'd0,   8'd0,   8'd0,   1'b0);
    send_macropixel(8'd0,   8'd128, 8'd255, 8'd0,   1'b0);
    // frame end on an even column, then on an odd one
    send_macropixel(8'd90,  8'd81,  8'd240, 8'd0,   1'b1);
    send_macropixel(8'd240, 8'd145, 8'd34,  8'd0,   1'b0);
    send_macropixel(8'd16,  8'd16,  8'd16,  8'd16,  1'b1);
    send_macropixel(8'd1,   8'd254, 8'd127, 8'd128, 1'b0);
    send_macropixel(8'd127, 8'd1,   8'd129, 8'd85,  1'b0);
    send_macropixel(8'd129, 8'd15,  8'd1,   8'd170, 1'b0);
    send_macropixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
    send_macropixel(8'd255, 8'd128, 8'd0,   8'd0,   1'b0);
    send_random(150, 0);

    write_line_bytes(15'd16384);
    send_random(120, 60);
    // above the maximum pitch; no frame end so the column runs on
    write_line_bytes(15'h7fff);
    send_random(60, 0);
    // shortest line, entered with the column far past its end
    write_line_bytes(15'd8);
    send_random(200, 50);
    write_line_bytes(15'd0);
    send_random(60, 0);
    write_line_bytes(15'd7);
    send_random(60, 0);
    write_line_bytes(15'd13);
    send_random(100, 40);
    write_line_bytes(15'd24);
    send_random(150, 60);
    repeat (3) begin
      pitch = y422q_pkg::CfgW'($urandom_range(8, 200));
      write_line_bytes(pitch);
      send_random(100, 4 * int'(pitch));
    end

    write_line_bytes(15'd40);
    quiet_tail = 1'b1;
    send_random(250, 160);

    drain_pixels();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ycbcr422_to_bgra_quarter_scale regression: pass");
    end else begin
      $display("ycbcr422_to_bgra_quarter_scale regression: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("ycbcr422_to_bgra_quarter_scale regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/y422q_pkg.sv
rtl/y422q_front.sv
rtl/y422q_queue.sv
rtl/y422q_back.sv
rtl/ycbcr422_to_bgra_quarter_scale.sv
bench/ycbcr422_to_bgra_quarter_scale_checker.sv
bench/ycbcr422_to_bgra_quarter_scale_tb.sv
